// File: rtl/core/tpc_pkg.sv
// Shared widths, constants and transfer structs for the three-point circumradius pipeline.
// No dependencies; every module of the block imports this package.
package tpc_pkg;

    localparam int COORD_BITS = 12;
    localparam int FRAC_BITS  = 8;

    localparam int IN_W  = 12;
    localparam int OUT_W = 32;

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int SUM_W  = COORD_BITS + 1;
    localparam int PROD_W = 2 * COORD_BITS + 2;
    localparam int NUM_W  = 3 * COORD_BITS + 3;
    localparam int NMAG_W = 3 * COORD_BITS + 2;
    localparam int DVS_W  = 2 * COORD_BITS + 2;
    localparam int QUO_W  = NMAG_W + 1;

    localparam int WIDE_W = 64;
    localparam int DMAG_W = OUT_W - FRAC_BITS;
    localparam int SQ_W   = 2 * DMAG_W;
    localparam int RAD_W  = 64;
    localparam int ROOT_W = 32;
    localparam int SREM_W = ROOT_W + 4;

    localparam logic signed [WIDE_W-1:0] INT32_MAX_W = 64'sd2147483647;
    localparam logic signed [WIDE_W-1:0] INT32_MIN_W = -64'sd2147483648;

    typedef struct packed {
        logic [COORD_BITS-1:0] x1;
        logic [COORD_BITS-1:0] y1;
        logic [NMAG_W-1:0]     nmag_x;
        logic [NMAG_W-1:0]     nmag_y;
        logic                  neg_x;
        logic                  neg_y;
        logic [DVS_W-1:0]      dvs;
        logic                  coll;
    } front_t;

    typedef struct packed {
        logic [COORD_BITS-1:0] x1;
        logic [COORD_BITS-1:0] y1;
        logic [NMAG_W-1:0]     q_x;
        logic [NMAG_W-1:0]     q_y;
        logic                  neg_x;
        logic                  neg_y;
        logic                  coll;
    } div_t;

    typedef struct packed {
        logic [OUT_W-1:0] cx;
        logic [OUT_W-1:0] cy;
        logic             sat;
        logic             rsat;
        logic             coll;
    } side_t;

    typedef struct packed {
        logic [RAD_W-1:0] rad;
        side_t            side;
    } sq_in_t;

    typedef struct packed {
        logic [ROOT_W-1:0] root;
        side_t             side;
    } sq_out_t;

endpackage

// File: rtl/core/tpc_front.sv
// Front end: point differences, squared-distance terms, determinant and center numerators.
// Six register stages; depends on tpc_pkg.
module tpc_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   adv,
    input  logic                   in_vld,
    input  logic [tpc_pkg::IN_W-1:0] first_x,
    input  logic [tpc_pkg::IN_W-1:0] first_y,
    input  logic [tpc_pkg::IN_W-1:0] second_x,
    input  logic [tpc_pkg::IN_W-1:0] second_y,
    input  logic [tpc_pkg::IN_W-1:0] third_x,
    input  logic [tpc_pkg::IN_W-1:0] third_y,
    output logic                   out_vld,
    output tpc_pkg::front_t        out_data
);
    import tpc_pkg::*;

    logic [COORD_BITS-1:0] x1, y1, x2, y2, x3, y3;

    // stage 1
    logic [5:0]                 vld_reg;
    logic [COORD_BITS-1:0]      x1_s1_reg, y1_s1_reg;
    logic signed [DIFF_W-1:0]   a_s1_reg, b_s1_reg, c_s1_reg, d_s1_reg;
    logic [SUM_W-1:0]           sx2_reg, sy2_reg, sx3_reg, sy3_reg;
    // stage 2
    logic [COORD_BITS-1:0]      x1_s2_reg, y1_s2_reg;
    logic signed [DIFF_W-1:0]   a_s2_reg, b_s2_reg, c_s2_reg, d_s2_reg;
    logic signed [PROD_W-1:0]   p_ax_reg, p_by_reg, p_cx_reg, p_dy_reg, p_bc_reg, p_ad_reg;
    logic signed [PROD_W-1:0]   p_ax_next, p_by_next, p_cx_next, p_dy_next;
    logic signed [PROD_W-1:0]   p_bc_next, p_ad_next;
    // stage 3
    logic [COORD_BITS-1:0]      x1_s3_reg, y1_s3_reg;
    logic signed [DIFF_W-1:0]   a_s3_reg, b_s3_reg, c_s3_reg, d_s3_reg;
    logic signed [PROD_W-1:0]   e_reg, f_reg, det_s3_reg;
    // stage 4
    logic [COORD_BITS-1:0]      x1_s4_reg, y1_s4_reg;
    logic signed [NUM_W-1:0]    p_bf_reg, p_de_reg, p_ce_reg, p_af_reg;
    logic signed [NUM_W-1:0]    p_bf_next, p_de_next, p_ce_next, p_af_next;
    logic signed [PROD_W-1:0]   det_s4_reg;
    logic                       coll_s4_reg;
    // stage 5
    logic [COORD_BITS-1:0]      x1_s5_reg, y1_s5_reg;
    logic signed [NUM_W-1:0]    nx_reg, ny_reg;
    logic [DVS_W-1:0]           dvs_reg, dvs_next;
    logic                       det_neg_reg, coll_s5_reg;
    logic [PROD_W-1:0]          det_mag;
    // stage 6
    front_t                     s6_reg, s6_next;
    logic [NUM_W-1:0]           nx_mag, ny_mag;

    assign x1 = COORD_BITS'(first_x);
    assign y1 = COORD_BITS'(first_y);
    assign x2 = COORD_BITS'(second_x);
    assign y2 = COORD_BITS'(second_y);
    assign x3 = COORD_BITS'(third_x);
    assign y3 = COORD_BITS'(third_y);

    // x1^2 - x2^2 = (x1 - x2) * (x1 + x2)
    assign p_ax_next = PROD_W'(a_s1_reg) * $signed(PROD_W'(sx2_reg));
    assign p_by_next = PROD_W'(b_s1_reg) * $signed(PROD_W'(sy2_reg));
    assign p_cx_next = PROD_W'(c_s1_reg) * $signed(PROD_W'(sx3_reg));
    assign p_dy_next = PROD_W'(d_s1_reg) * $signed(PROD_W'(sy3_reg));
    assign p_bc_next = PROD_W'(b_s1_reg) * PROD_W'(c_s1_reg);
    assign p_ad_next = PROD_W'(a_s1_reg) * PROD_W'(d_s1_reg);

    assign p_bf_next = NUM_W'(b_s3_reg) * NUM_W'(f_reg);
    assign p_de_next = NUM_W'(d_s3_reg) * NUM_W'(e_reg);
    assign p_ce_next = NUM_W'(c_s3_reg) * NUM_W'(e_reg);
    assign p_af_next = NUM_W'(a_s3_reg) * NUM_W'(f_reg);

    assign det_mag  = det_s4_reg[PROD_W-1] ? PROD_W'(-det_s4_reg) : PROD_W'(det_s4_reg);
    assign dvs_next = {det_mag[DVS_W-2:0], 1'b0};

    assign nx_mag = nx_reg[NUM_W-1] ? NUM_W'(-nx_reg) : NUM_W'(nx_reg);
    assign ny_mag = ny_reg[NUM_W-1] ? NUM_W'(-ny_reg) : NUM_W'(ny_reg);

    always_comb
    begin
        s6_next.x1     = x1_s5_reg;
        s6_next.y1     = y1_s5_reg;
        s6_next.nmag_x = nx_mag[NMAG_W-1:0];
        s6_next.nmag_y = ny_mag[NMAG_W-1:0];
        s6_next.neg_x  = nx_reg[NUM_W-1] ^ det_neg_reg;
        s6_next.neg_y  = ny_reg[NUM_W-1] ^ det_neg_reg;
        s6_next.dvs    = dvs_reg;
        s6_next.coll   = coll_s5_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[4:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            x1_s1_reg <= x1;
            y1_s1_reg <= y1;
            a_s1_reg  <= $signed({1'b0, x1}) - $signed({1'b0, x2});
            b_s1_reg  <= $signed({1'b0, y1}) - $signed({1'b0, y2});
            c_s1_reg  <= $signed({1'b0, x1}) - $signed({1'b0, x3});
            d_s1_reg  <= $signed({1'b0, y1}) - $signed({1'b0, y3});
            sx2_reg   <= SUM_W'(x1) + SUM_W'(x2);
            sy2_reg   <= SUM_W'(y1) + SUM_W'(y2);
            sx3_reg   <= SUM_W'(x1) + SUM_W'(x3);
            sy3_reg   <= SUM_W'(y1) + SUM_W'(y3);

            x1_s2_reg <= x1_s1_reg;
            y1_s2_reg <= y1_s1_reg;
            a_s2_reg  <= a_s1_reg;
            b_s2_reg  <= b_s1_reg;
            c_s2_reg  <= c_s1_reg;
            d_s2_reg  <= d_s1_reg;
            p_ax_reg  <= p_ax_next;
            p_by_reg  <= p_by_next;
            p_cx_reg  <= p_cx_next;
            p_dy_reg  <= p_dy_next;
            p_bc_reg  <= p_bc_next;
            p_ad_reg  <= p_ad_next;

            x1_s3_reg  <= x1_s2_reg;
            y1_s3_reg  <= y1_s2_reg;
            a_s3_reg   <= a_s2_reg;
            b_s3_reg   <= b_s2_reg;
            c_s3_reg   <= c_s2_reg;
            d_s3_reg   <= d_s2_reg;
            e_reg      <= p_ax_reg + p_by_reg;
            f_reg      <= p_cx_reg + p_dy_reg;
            det_s3_reg <= p_bc_reg - p_ad_reg;

            x1_s4_reg   <= x1_s3_reg;
            y1_s4_reg   <= y1_s3_reg;
            p_bf_reg    <= p_bf_next;
            p_de_reg    <= p_de_next;
            p_ce_reg    <= p_ce_next;
            p_af_reg    <= p_af_next;
            det_s4_reg  <= det_s3_reg;
            coll_s4_reg <= (det_s3_reg == '0);

            x1_s5_reg   <= x1_s4_reg;
            y1_s5_reg   <= y1_s4_reg;
            nx_reg      <= p_bf_reg - p_de_reg;
            ny_reg      <= p_ce_reg - p_af_reg;
            dvs_reg     <= dvs_next;
            det_neg_reg <= det_s4_reg[PROD_W-1];
            coll_s5_reg <= coll_s4_reg;

            s6_reg <= s6_next;
        end
    end

    assign out_vld  = vld_reg[5];
    assign out_data = s6_reg;

endmodule

// File: rtl/core/tpc_div.sv
// Pipelined restoring divider: both center numerators over the doubled determinant,
// one quotient bit per stage. Depends on tpc_pkg.
module tpc_div (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            adv,
    input  logic            in_vld,
    input  tpc_pkg::front_t in_data,
    output logic            out_vld,
    output tpc_pkg::div_t   out_data
);
    import tpc_pkg::*;

    typedef struct packed {
        logic [DVS_W-1:0]      rem_x;
        logic [DVS_W-1:0]      rem_y;
        logic [NMAG_W-1:0]     n_x;
        logic [NMAG_W-1:0]     n_y;
        logic [NMAG_W-1:0]     q_x;
        logic [NMAG_W-1:0]     q_y;
        logic [DVS_W-1:0]      dvs;
        logic [COORD_BITS-1:0] x1;
        logic [COORD_BITS-1:0] y1;
        logic                  neg_x;
        logic                  neg_y;
        logic                  coll;
    } dstage_t;

    dstage_t             stg_in [NMAG_W];
    dstage_t             stg_reg [NMAG_W];
    dstage_t             stg_next [NMAG_W];
    logic [NMAG_W-1:0]   vld_reg;

    // one restoring step: returns {new remainder, quotient bit}
    function automatic logic [DVS_W:0] div_step(
        input logic [DVS_W-1:0] rem,
        input logic             nbit,
        input logic [DVS_W-1:0] dvs
    );
        logic [DVS_W:0] t;
        logic [DVS_W:0] diff;
        logic           ge;
        t    = {rem, nbit};
        diff = t - {1'b0, dvs};
        ge   = (t >= {1'b0, dvs});
        return ge ? {diff[DVS_W-1:0], 1'b1} : {t[DVS_W-1:0], 1'b0};
    endfunction

    always_comb
    begin
        stg_in[0].rem_x = '0;
        stg_in[0].rem_y = '0;
        stg_in[0].n_x   = in_data.nmag_x;
        stg_in[0].n_y   = in_data.nmag_y;
        stg_in[0].q_x   = '0;
        stg_in[0].q_y   = '0;
        stg_in[0].dvs   = in_data.dvs;
        stg_in[0].x1    = in_data.x1;
        stg_in[0].y1    = in_data.y1;
        stg_in[0].neg_x = in_data.neg_x;
        stg_in[0].neg_y = in_data.neg_y;
        stg_in[0].coll  = in_data.coll;
    end

    genvar k;
    generate
        for (k = 0; k < NMAG_W; k++)
        begin : g_stage
            logic [DVS_W:0] step_x, step_y;

            if (k > 0)
            begin : g_link
                assign stg_in[k] = stg_reg[k-1];
            end

            assign step_x = div_step(stg_in[k].rem_x, stg_in[k].n_x[NMAG_W-1], stg_in[k].dvs);
            assign step_y = div_step(stg_in[k].rem_y, stg_in[k].n_y[NMAG_W-1], stg_in[k].dvs);

            always_comb
            begin
                stg_next[k]       = stg_in[k];
                stg_next[k].rem_x = step_x[DVS_W:1];
                stg_next[k].rem_y = step_y[DVS_W:1];
                stg_next[k].n_x   = stg_in[k].n_x << 1;
                stg_next[k].n_y   = stg_in[k].n_y << 1;
                stg_next[k].q_x   = {stg_in[k].q_x[NMAG_W-2:0], step_x[0]};
                stg_next[k].q_y   = {stg_in[k].q_y[NMAG_W-2:0], step_y[0]};
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    stg_reg[k] <= stg_next[k];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[NMAG_W-2:0], in_vld};
        end
    end

    assign out_vld        = vld_reg[NMAG_W-1];
    assign out_data.x1    = stg_reg[NMAG_W-1].x1;
    assign out_data.y1    = stg_reg[NMAG_W-1].y1;
    assign out_data.q_x   = stg_reg[NMAG_W-1].q_x;
    assign out_data.q_y   = stg_reg[NMAG_W-1].q_y;
    assign out_data.neg_x = stg_reg[NMAG_W-1].neg_x;
    assign out_data.neg_y = stg_reg[NMAG_W-1].neg_y;
    assign out_data.coll  = stg_reg[NMAG_W-1].coll;

endmodule

// File: rtl/core/tpc_post.sv
// Center signing and clamping, offset to the first point and its squared length.
// Five register stages; depends on tpc_pkg.
module tpc_post (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_vld,
    input  tpc_pkg::div_t    in_data,
    output logic             out_vld,
    output tpc_pkg::sq_in_t  out_data
);
    import tpc_pkg::*;

    logic [4:0]                 vld_reg;
    // stage 1: signed center
    logic signed [QUO_W-1:0]    cx_reg, cy_reg;
    logic [COORD_BITS-1:0]      x1_p1_reg, y1_p1_reg;
    logic                       coll_p1_reg;
    logic signed [QUO_W-1:0]    qx_pos, qy_pos;
    // stage 2: clamp and offset
    logic signed [WIDE_W-1:0]   cx_w, cy_w;
    logic [OUT_W-1:0]           cx32_next, cy32_next;
    logic                       sat_next;
    logic [OUT_W-1:0]           cx32_reg, cy32_reg;
    logic                       sat_p2_reg, coll_p2_reg;
    logic signed [WIDE_W-1:0]   dx_reg, dy_reg;
    // stage 3: magnitudes
    logic [WIDE_W-1:0]          dx_mag, dy_mag;
    logic [DMAG_W-1:0]          dmx_reg, dmy_reg;
    logic                       over_p3_reg;
    side_t                      side_p3_reg;
    // stage 4: squares
    logic [SQ_W-1:0]            sqx_reg, sqy_reg;
    logic                       over_p4_reg;
    side_t                      side_p4_reg;
    // stage 5: sum
    logic [SQ_W:0]              ssum;
    sq_in_t                     p5_reg, p5_next;

    assign qx_pos = $signed({1'b0, in_data.q_x});
    assign qy_pos = $signed({1'b0, in_data.q_y});

    assign cx_w = WIDE_W'(cx_reg);
    assign cy_w = WIDE_W'(cy_reg);

    always_comb
    begin
        sat_next  = 1'b0;
        cx32_next = cx_w[OUT_W-1:0];
        cy32_next = cy_w[OUT_W-1:0];
        if (cx_w > INT32_MAX_W)
        begin
            cx32_next = INT32_MAX_W[OUT_W-1:0];
            sat_next  = 1'b1;
        end
        else if (cx_w < INT32_MIN_W)
        begin
            cx32_next = INT32_MIN_W[OUT_W-1:0];
            sat_next  = 1'b1;
        end
        if (cy_w > INT32_MAX_W)
        begin
            cy32_next = INT32_MAX_W[OUT_W-1:0];
            sat_next  = 1'b1;
        end
        else if (cy_w < INT32_MIN_W)
        begin
            cy32_next = INT32_MIN_W[OUT_W-1:0];
            sat_next  = 1'b1;
        end
    end

    assign dx_mag = dx_reg[WIDE_W-1] ? WIDE_W'(-dx_reg) : WIDE_W'(dx_reg);
    assign dy_mag = dy_reg[WIDE_W-1] ? WIDE_W'(-dy_reg) : WIDE_W'(dy_reg);

    assign ssum = (SQ_W+1)'(sqx_reg) + (SQ_W+1)'(sqy_reg);

    always_comb
    begin
        p5_next           = '0;
        p5_next.rad       = RAD_W'(ssum[SQ_W-1:0]) << (2 * FRAC_BITS);
        p5_next.side      = side_p4_reg;
        p5_next.side.rsat = over_p4_reg | ssum[SQ_W];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[3:0], in_vld};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            cx_reg      <= in_data.neg_x ? -qx_pos : qx_pos;
            cy_reg      <= in_data.neg_y ? -qy_pos : qy_pos;
            x1_p1_reg   <= in_data.x1;
            y1_p1_reg   <= in_data.y1;
            coll_p1_reg <= in_data.coll;

            cx32_reg    <= cx32_next;
            cy32_reg    <= cy32_next;
            sat_p2_reg  <= sat_next;
            coll_p2_reg <= coll_p1_reg;
            // offset is taken from the unclamped center
            dx_reg      <= $signed(WIDE_W'(x1_p1_reg)) - cx_w;
            dy_reg      <= $signed(WIDE_W'(y1_p1_reg)) - cy_w;

            dmx_reg          <= dx_mag[DMAG_W-1:0];
            dmy_reg          <= dy_mag[DMAG_W-1:0];
            over_p3_reg      <= (|dx_mag[WIDE_W-1:DMAG_W]) | (|dy_mag[WIDE_W-1:DMAG_W]);
            side_p3_reg.cx   <= cx32_reg;
            side_p3_reg.cy   <= cy32_reg;
            side_p3_reg.sat  <= sat_p2_reg;
            side_p3_reg.rsat <= 1'b0;
            side_p3_reg.coll <= coll_p2_reg;

            sqx_reg     <= SQ_W'(dmx_reg) * SQ_W'(dmx_reg);
            sqy_reg     <= SQ_W'(dmy_reg) * SQ_W'(dmy_reg);
            over_p4_reg <= over_p3_reg;
            side_p4_reg <= side_p3_reg;

            p5_reg <= p5_next;
        end
    end

    assign out_vld  = vld_reg[4];
    assign out_data = p5_reg;

endmodule

// File: rtl/core/tpc_sqrt.sv
// Pipelined integer square root, one root bit per stage over a 64-bit radicand.
// Depends on tpc_pkg.
module tpc_sqrt (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             adv,
    input  logic             in_vld,
    input  tpc_pkg::sq_in_t  in_data,
    output logic             out_vld,
    output tpc_pkg::sq_out_t out_data
);
    import tpc_pkg::*;

    typedef struct packed {
        logic [SREM_W-1:0] rem;
        logic [ROOT_W-1:0] root;
        logic [RAD_W-1:0]  rad;
        side_t             side;
    } sstage_t;

    sstage_t           stg_in [ROOT_W];
    sstage_t           stg_reg [ROOT_W];
    sstage_t           stg_next [ROOT_W];
    logic [ROOT_W-1:0] vld_reg;

    always_comb
    begin
        stg_in[0].rem  = '0;
        stg_in[0].root = '0;
        stg_in[0].rad  = in_data.rad;
        stg_in[0].side = in_data.side;
    end

    genvar k;
    generate
        for (k = 0; k < ROOT_W; k++)
        begin : g_stage
            logic [SREM_W-1:0] t;
            logic [SREM_W-1:0] trial;
            logic              ge;

            if (k > 0)
            begin : g_link
                assign stg_in[k] = stg_reg[k-1];
            end

            // bring down the next two radicand bits
            assign t     = {stg_in[k].rem[SREM_W-3:0], stg_in[k].rad[RAD_W-1-2*k -: 2]};
            assign trial = SREM_W'({stg_in[k].root, 2'b01});
            assign ge    = (t >= trial);

            always_comb
            begin
                stg_next[k]      = stg_in[k];
                stg_next[k].rem  = ge ? (t - trial) : t;
                stg_next[k].root = {stg_in[k].root[ROOT_W-2:0], ge};
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    stg_reg[k] <= stg_next[k];
                end
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[ROOT_W-2:0], in_vld};
        end
    end

    assign out_vld       = vld_reg[ROOT_W-1];
    assign out_data.root = stg_reg[ROOT_W-1].root;
    assign out_data.side = stg_reg[ROOT_W-1].side;

endmodule

// File: rtl/core/three_point_circumradius.sv
// Top level of the three-point circumradius pipeline and its output register.
// Depends on tpc_pkg, tpc_front, tpc_div, tpc_post and tpc_sqrt.
//
//   channel | valid     | stall     | payload
//   --------+-----------+-----------+-------------------------------------------------
//   input   | in_valid  | in_stall  | first_x first_y second_x second_y third_x third_y
//   output  | out_valid | out_stall | radius_fixed center_x center_y collinear saturated
//
// One transfer in per cycle while in_stall is low. The divider (one quotient bit per
// stage) and the square root (one root bit per stage) form most of the pipeline depth.
// rst_n clears all valid bits at once; payload registers are not reset.
// A stalled result holds the whole pipeline, and in_stall follows it in the same cycle.
module three_point_circumradius (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [tpc_pkg::IN_W-1:0] first_x,
    input  logic [tpc_pkg::IN_W-1:0] first_y,
    input  logic [tpc_pkg::IN_W-1:0] second_x,
    input  logic [tpc_pkg::IN_W-1:0] second_y,
    input  logic [tpc_pkg::IN_W-1:0] third_x,
    input  logic [tpc_pkg::IN_W-1:0] third_y,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [tpc_pkg::OUT_W-1:0] radius_fixed,
    output logic signed [tpc_pkg::OUT_W-1:0] center_x,
    output logic signed [tpc_pkg::OUT_W-1:0] center_y,
    output logic                     collinear,
    output logic                     saturated
);
    import tpc_pkg::*;

    logic     adv;
    logic     front_vld, div_vld, post_vld, sqrt_vld;
    front_t   front_data;
    div_t     div_data;
    sq_in_t   post_data;
    sq_out_t  sqrt_data;

    logic              out_vld_reg;
    logic [OUT_W-1:0]  radius_reg, cx_reg, cy_reg;
    logic              coll_reg, sat_reg;

    // advance everything unless a finished result is held
    assign adv = !(out_vld_reg && out_stall);

    tpc_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (in_valid),
        .first_x  (first_x),
        .first_y  (first_y),
        .second_x (second_x),
        .second_y (second_y),
        .third_x  (third_x),
        .third_y  (third_y),
        .out_vld  (front_vld),
        .out_data (front_data)
    );

    tpc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (front_vld),
        .in_data  (front_data),
        .out_vld  (div_vld),
        .out_data (div_data)
    );

    tpc_post u_post (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (div_vld),
        .in_data  (div_data),
        .out_vld  (post_vld),
        .out_data (post_data)
    );

    tpc_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .adv      (adv),
        .in_vld   (post_vld),
        .in_data  (post_data),
        .out_vld  (sqrt_vld),
        .out_data (sqrt_data)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_vld_reg <= sqrt_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            coll_reg <= sqrt_data.side.coll;
            if (sqrt_data.side.coll)
            begin
                radius_reg <= '0;
                cx_reg     <= '0;
                cy_reg     <= '0;
                sat_reg    <= 1'b0;
            end
            else
            begin
                radius_reg <= sqrt_data.side.rsat ? '1 : sqrt_data.root;
                cx_reg     <= sqrt_data.side.cx;
                cy_reg     <= sqrt_data.side.cy;
                sat_reg    <= sqrt_data.side.sat | sqrt_data.side.rsat;
            end
        end
    end

    assign in_stall     = !adv;
    assign out_valid    = out_vld_reg;
    assign radius_fixed = radius_reg;
    assign center_x     = $signed(cx_reg);
    assign center_y     = $signed(cy_reg);
    assign collinear    = coll_reg;
    assign saturated    = sat_reg;

endmodule

// File: rtl/core/tpc_checker.sv
// Port-level checks for three_point_circumradius, attached with a bind.
// Depends on tpc_pkg for port widths.
module tpc_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      in_valid,
    input logic                      in_stall,
    input logic                      out_valid,
    input logic                      out_stall,
    input logic [tpc_pkg::OUT_W-1:0] radius_fixed,
    input logic [tpc_pkg::OUT_W-1:0] center_x,
    input logic [tpc_pkg::OUT_W-1:0] center_y,
    input logic                      collinear,
    input logic                      saturated
);
    import tpc_pkg::*;

    // input side holds exactly when a finished result is held
    a_stall_link : assert property (@(posedge clk) disable iff (!rst_n)
        in_stall == (out_valid && out_stall))
        else $error("in_stall does not follow a held result");

    a_collinear_zero : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && collinear |->
            radius_fixed == '0 && center_x == '0 && center_y == '0 && !saturated)
        else $error("collinear result carries nonzero fields");

    a_hold : assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=>
            out_valid && $stable(radius_fixed) && $stable(center_x) && $stable(center_y)
            && $stable(collinear) && $stable(saturated))
        else $error("held result changed");

    a_no_in_stall_idle : assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> !in_stall)
        else $error("input stalled with no result pending");

endmodule

bind three_point_circumradius tpc_checker u_tpc_checker (.*);

// File: sim/three_point_circumradius_tb.sv
// Self-checking testbench for three_point_circumradius: directed point triples, then random ones.
// Depends on tpc_pkg and three_point_circumradius RTL; checked by a local model or fixed values.
`timescale 1ns / 100ps

module three_point_circumradius_tb;

    import tpc_pkg::*;

    localparam int  N_RANDOM    = 700;
    localparam int  CYCLE_LIMIT = 400000;
    localparam int  DRAIN_WAIT  = 200;
    localparam int  MAX_REPORTS = 10;
    localparam int  IDLE_PCT    = 38;

    typedef enum int {PICK_UNIFORM, PICK_NEAR_LINE, PICK_ON_LINE, PICK_TINY} pick_e;

    typedef struct packed {
        logic [OUT_W-1:0]        radius;
        logic signed [OUT_W-1:0] cx;
        logic signed [OUT_W-1:0] cy;
        logic                    coll;
        logic                    sat;
    } circle_t;

    typedef struct packed {
        logic [IN_W-1:0] x1;
        logic [IN_W-1:0] y1;
        logic [IN_W-1:0] x2;
        logic [IN_W-1:0] y2;
        logic [IN_W-1:0] x3;
        logic [IN_W-1:0] y3;
        logic            typed;
        circle_t         known;
    } triple_t;

    localparam circle_t ON_LINE = '{radius: '0, cx: '0, cy: '0, coll: 1'b1, sat: 1'b0};
    localparam circle_t NONE    = '0;

    logic                      clk;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_stall;
    logic [IN_W-1:0]           first_x;
    logic [IN_W-1:0]           first_y;
    logic [IN_W-1:0]           second_x;
    logic [IN_W-1:0]           second_y;
    logic [IN_W-1:0]           third_x;
    logic [IN_W-1:0]           third_y;
    logic                      out_valid;
    logic                      out_stall;
    logic [OUT_W-1:0]          radius_fixed;
    logic signed [OUT_W-1:0]   center_x;
    logic signed [OUT_W-1:0]   center_y;
    logic                      collinear;
    logic                      saturated;

    circle_t  pending_circles[$];
    triple_t  directed_rows[$];
    int       mismatches;
    int       cycles;
    bit       calm;

    three_point_circumradius u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .first_x      (first_x),
        .first_y      (first_y),
        .second_x     (second_x),
        .second_y     (second_y),
        .third_x      (third_x),
        .third_y      (third_y),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .radius_fixed (radius_fixed),
        .center_x     (center_x),
        .center_y     (center_y),
        .collinear    (collinear),
        .saturated    (saturated)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    function automatic longint unsigned int_sqrt(longint unsigned v);
        longint unsigned root;
        longint unsigned bitv;
        root = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= root + bitv)
            begin
                v    = v - (root + bitv);
                root = (root >> 1) + bitv;
            end
            else
                root = root >> 1;
            bitv = bitv >> 2;
        end
        return root;
    endfunction

    function automatic logic [OUT_W-1:0] clamp_center(longint v, ref logic sat);
        if (v > 64'sd2147483647)
        begin
            sat = 1'b1;
            return 32'h7FFF_FFFF;
        end
        if (v < -64'sd2147483648)
        begin
            sat = 1'b1;
            return 32'h8000_0000;
        end
        return v[OUT_W-1:0];
    endfunction

    function automatic circle_t predict_circle(triple_t t);
        longint          x1, y1, x2, y2, x3, y3;
        longint          a, b, c, d, e2, f2, det, cx, cy;
        longint unsigned dx, dy, s, root;
        longint unsigned lim;
        logic            sat;
        circle_t         r;
        x1 = longint'(t.x1); y1 = longint'(t.y1);
        x2 = longint'(t.x2); y2 = longint'(t.y2);
        x3 = longint'(t.x3); y3 = longint'(t.y3);
        a = x1 - x2; b = y1 - y2; c = x1 - x3; d = y1 - y3;
        e2 = (x1 * x1 - x2 * x2) + (y1 * y1 - y2 * y2);
        f2 = (x1 * x1 - x3 * x3) + (y1 * y1 - y3 * y3);
        det = b * c - a * d;
        lim = 64'd1 << (32 - FRAC_BITS);
        sat = 1'b0;
        r = '0;
        if (det == 0)
            return ON_LINE;
        // signed division truncates toward zero
        cx = (b * f2 - d * e2) / (2 * det);
        cy = (c * e2 - a * f2) / (2 * det);
        r.cx = clamp_center(cx, sat);
        r.cy = clamp_center(cy, sat);
        dx = (x1 - cx < 0) ? -(x1 - cx) : (x1 - cx);
        dy = (y1 - cy < 0) ? -(y1 - cy) : (y1 - cy);
        if (dx >= lim || dy >= lim)
        begin
            r.radius = 32'hFFFF_FFFF;
            sat = 1'b1;
        end
        else
        begin
            s = dx * dx + dy * dy;
            if ((s >> (64 - 2 * FRAC_BITS)) != 0)
            begin
                r.radius = 32'hFFFF_FFFF;
                sat = 1'b1;
            end
            else
            begin
                root = int_sqrt(s << (2 * FRAC_BITS));
                if (root > 64'hFFFF_FFFF)
                begin
                    r.radius = 32'hFFFF_FFFF;
                    sat = 1'b1;
                end
                else
                    r.radius = root[OUT_W-1:0];
            end
        end
        r.coll = 1'b0;
        r.sat  = sat;
        return r;
    endfunction

    function automatic triple_t point_row(int x1, int y1, int x2, int y2, int x3, int y3,
                                          bit typed, circle_t known);
        triple_t t;
        t.x1 = IN_W'(x1); t.y1 = IN_W'(y1);
        t.x2 = IN_W'(x2); t.y2 = IN_W'(y2);
        t.x3 = IN_W'(x3); t.y3 = IN_W'(y3);
        t.typed = typed;
        t.known = known;
        return t;
    endfunction

    function automatic int clip_coord(int v);
        if (v < 0)
            return 0;
        if (v > 4095)
            return 4095;
        return v;
    endfunction

    function automatic triple_t random_triple();
        triple_t t;
        pick_e   pick;
        int      k, x1, y1, x2, y2;
        k = int'($urandom_range(99));
        pick = (k < 60) ? PICK_UNIFORM : (k < 75) ? PICK_NEAR_LINE :
               (k < 85) ? PICK_ON_LINE : PICK_TINY;
        t = '0;
        x1 = int'($urandom_range(4095)); y1 = int'($urandom_range(4095));
        x2 = int'($urandom_range(4095)); y2 = int'($urandom_range(4095));
        t.x1 = IN_W'(x1); t.y1 = IN_W'(y1); t.x2 = IN_W'(x2); t.y2 = IN_W'(y2);
        case (pick)
            PICK_UNIFORM:
            begin
                t.x3 = IN_W'($urandom_range(4095));
                t.y3 = IN_W'($urandom_range(4095));
            end
            PICK_NEAR_LINE:
            begin
                // nudge the midpoint by at most one per axis: tiny or zero det, far center
                t.x3 = IN_W'(clip_coord((x1 + x2) / 2 + int'($urandom_range(2)) - 1));
                t.y3 = IN_W'(clip_coord((y1 + y2) / 2 + int'($urandom_range(2)) - 1));
            end
            PICK_ON_LINE:
            begin
                if ($urandom_range(1))
                begin
                    t.x2 = IN_W'(x1);
                    t.x3 = IN_W'(x1);
                    t.y3 = IN_W'($urandom_range(4095));
                end
                else
                begin
                    t.x2 = IN_W'(x1 & 'h7FE);
                    t.y2 = IN_W'(y1 & 'h7FE);
                    t.x1 = IN_W'(t.x2 * 2);
                    t.y1 = IN_W'(t.y2 * 2);
                    t.x3 = '0;
                    t.y3 = '0;
                end
            end
            default:
            begin
                t.x1 = IN_W'($urandom_range(15)); t.y1 = IN_W'($urandom_range(15));
                t.x2 = IN_W'($urandom_range(15)); t.y2 = IN_W'($urandom_range(15));
                t.x3 = IN_W'($urandom_range(15)); t.y3 = IN_W'($urandom_range(15));
            end
        endcase
        return t;
    endfunction

    task automatic send_triple(triple_t t);
        @(negedge clk);
        first_x  = t.x1;
        first_y  = t.y1;
        second_x = t.x2;
        second_y = t.y2;
        third_x  = t.x3;
        third_y  = t.y3;
        in_valid = 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        pending_circles.push_back(t.typed ? t.known : predict_circle(t));
        // drop valid for a random number of idle cycles
        while (!calm && $urandom_range(99) < IDLE_PCT)
        begin
            @(negedge clk);
            in_valid = 1'b0;
        end
    endtask

    // receiver stalls at random, except in the calm stretch
    always @(negedge clk)
        out_stall = (!calm && $urandom_range(99) < IDLE_PCT);

    always @(posedge clk)
    begin
        circle_t got;
        circle_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got = '{radius: radius_fixed, cx: center_x, cy: center_y,
                    coll: collinear, sat: saturated};
            if (pending_circles.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result: r=%h cx=%0d cy=%0d coll=%b sat=%b",
                             got.radius, got.cx, got.cy, got.coll, got.sat);
            end
            else
            begin
                want = pending_circles.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"mismatch: exp r=%h cx=%0d cy=%0d coll=%b sat=%b",
                                  " | got r=%h cx=%0d cy=%0d coll=%b sat=%b"},
                                 want.radius, want.cx, want.cy, want.coll, want.sat,
                                 got.radius, got.cx, got.cy, got.coll, got.sat);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("three_point_circumradius_tb: errors");
            $finish;
        end
    end

    initial
    begin
        mismatches = 0;
        cycles     = 0;
        calm       = 1'b0;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        out_stall  = 1'b0;
        first_x    = '0;
        first_y    = '0;
        second_x   = '0;
        second_y   = '0;
        third_x    = '0;
        third_y    = '0;

        directed_rows.push_back(point_row(0, 0, 0, 0, 0, 0, 1, ON_LINE));
        directed_rows.push_back(point_row(4095, 4095, 4095, 4095, 4095, 4095, 1, ON_LINE));
        directed_rows.push_back(point_row(5, 0, 5, 100, 5, 4095, 1, ON_LINE));
        directed_rows.push_back(point_row(0, 7, 4095, 7, 2000, 7, 1, ON_LINE));
        directed_rows.push_back(point_row(0, 0, 2048, 2048, 4094, 4094, 1, ON_LINE));
        directed_rows.push_back(point_row(0, 0, 4095, 0, 0, 4095, 0, NONE));
        directed_rows.push_back(point_row(4095, 4095, 0, 4095, 4095, 0, 0, NONE));
        directed_rows.push_back(point_row(0, 0, 2, 0, 0, 2, 0, NONE));
        directed_rows.push_back(point_row(0, 0, 4095, 4094, 4094, 4093, 0, NONE));
        directed_rows.push_back(point_row(4095, 4095, 0, 1, 1, 2, 0, NONE));
        directed_rows.push_back(point_row(4095, 0, 0, 4094, 1, 4093, 0, NONE));
        directed_rows.push_back(point_row(0, 4095, 4095, 1, 4094, 2, 0, NONE));
        directed_rows.push_back(point_row(12'hAAA, 12'h555, 12'h555, 12'hAAA, 12'hFFF, 12'h000,
                                          0, NONE));
        directed_rows.push_back(point_row(12'h555, 12'hAAA, 12'hAAA, 12'h555, 12'h000, 12'hFFF,
                                          0, NONE));
        directed_rows.push_back(point_row(1, 1, 0, 0, 1, 0, 0, NONE));

        repeat (3)
            @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (directed_rows[i])
            send_triple(directed_rows[i]);

        for (int n = 0; n < N_RANDOM; n++)
        begin
            calm = (n >= 300 && n < 420);
            send_triple(random_triple());
        end
        calm = 1'b0;

        @(negedge clk);
        in_valid = 1'b0;
        while (pending_circles.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT)
            @(posedge clk);

        if (mismatches == 0 && pending_circles.size() == 0)
            $display("three_point_circumradius_tb: clean");
        else
            $display("three_point_circumradius_tb: errors");
        $finish;
    end

endmodule

// File: files.f
rtl/core/tpc_pkg.sv
rtl/core/tpc_front.sv
rtl/core/tpc_div.sv
rtl/core/tpc_post.sv
rtl/core/tpc_sqrt.sv
rtl/core/three_point_circumradius.sv
rtl/core/tpc_checker.sv
sim/three_point_circumradius_tb.sv
